// ===== sv/maze_flood_fill_distance_unit_macros.svh =====
// Assertion macros shared by the flood fill checker.
`ifndef MAZE_FLOOD_FILL_DISTANCE_UNIT_MACROS_SVH
`define MAZE_FLOOD_FILL_DISTANCE_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define MFFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define MFFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/mffd_pkg.sv =====
// Types, constants and helper functions of the maze flood fill distance unit.
package mffd_pkg;

  localparam int MFFD_MAZE_SIDE   = 16;
  localparam int MFFD_QUEUE_DEPTH = 256;
  localparam int CELLS            = 256;
  localparam int LEVEL_W          = 9;
  localparam int QUEUE_W          = 17;

  localparam logic [2:0] GOAL_33     = 3'd0;
  localparam logic [2:0] GOAL_77     = 3'd1;
  localparam logic [2:0] GOAL_CENTER = 3'd2;
  localparam logic [2:0] GOAL_START  = 3'd3;
  localparam logic [2:0] GOAL_GIVEN  = 3'd4;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_RECORD = 2'd1,
    OP_FLOOD  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_KNOWN       = 2'd1,
    STAT_NOT_REACHED = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_WR,
    S_REC_CELL,
    S_REC_NB,
    S_REC_NWR,
    S_FL_CLR,
    S_FL_SEED,
    S_FL_POP,
    S_FL_CELL,
    S_FL_WALL,
    S_FL_NRD,
    S_FL_NCHK,
    S_FL_END,
    S_RES_DIST
  } state_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] cell_req;
    logic [3:0] walls;
    logic [2:0] goal_mode;
    logic [7:0] mouse_cell;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [LEVEL_W-1:0]   distance;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] addr;
  } nb_t;

  // Neighbor of a cell in direction d (0 N, 1 E, 2 S, 3 W).
  function automatic nb_t neighbor(input logic [7:0] cid, input logic [1:0] d,
                                   input logic [4:0] side);
    logic [4:0] x;
    logic [4:0] y;
    logic       ok;
    nb_t        r;
    x  = {1'b0, cid[7:4]};
    y  = {1'b0, cid[3:0]};
    ok = 1'b1;
    case (d)
      2'd0: y = y + 5'd1;
      2'd1: x = x + 5'd1;
      2'd2: begin
        if (y == 5'd0) ok = 1'b0;
        y = y - 5'd1;
      end
      default: begin
        if (x == 5'd0) ok = 1'b0;
        x = x - 5'd1;
      end
    endcase
    r.valid = ok && (x < side) && (y < side);
    r.addr  = {x[3:0], y[3:0]};
    return r;
  endfunction

  // Wall and known bits that the border setup adds to one cell.
  function automatic logic [7:0] border_mask(input logic [7:0] cid, input logic [4:0] side);
    logic [4:0] x;
    logic [4:0] y;
    logic [7:0] m;
    x = {1'b0, cid[7:4]};
    y = {1'b0, cid[3:0]};
    m = 8'h00;
    if (x < side && y < side) begin
      if (x == 5'd0) m = m | 8'h88;
      if (y == 5'd0) m = m | 8'h44;
      if (x == side - 5'd1) m = m | 8'h22;
      if (y == side - 5'd1) m = m | 8'h11;
    end
    if (cid == 8'h00) m = m | 8'hF2;
    if (cid == 8'h10) m = m | 8'h88;
    return m;
  endfunction

  // Goal cell number k of a goal mode.
  function automatic logic [7:0] seed_cell(input logic [2:0] mode, input logic [1:0] k,
                                           input logic [7:0] goal);
    logic [7:0] c;
    case (mode)
      GOAL_33:    c = 8'h33;
      GOAL_77:    c = 8'h77;
      GOAL_CENTER: begin
        case (k)
          2'd0:    c = 8'h77;
          2'd1:    c = 8'h78;
          2'd2:    c = 8'h87;
          default: c = 8'h88;
        endcase
      end
      GOAL_START: c = 8'h00;
      default:    c = goal;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/mffd_ram.sv =====
// Simple dual port synchronous RAM with a registered read.
module mffd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/maze_flood_fill_distance_unit.sv =====
// Top level of the maze flood fill distance unit: command sequencer and its three memories.
//
// The unit keeps a wall map and a distance map of a micromouse maze in two
// 256-entry synchronous RAMs, and a frontier queue in a third. A command is
// taken on a transfer where start is high and busy is low; busy then stays
// high while the command runs and falls in the very cycle in which the single
// result is shown on result with done high, so the next command can be taken
// in that cycle. The receiver cannot stall, so the result must be sampled in
// that cycle. After reset the unit sweeps both maps to zero, one cell per
// cycle, and holds busy high until the sweep ends; only then is the first
// command taken. Border setup does one read-modify-write per cell,
// pipelined through the wall RAM. A flood fill first clears the distance
// RAM, seeds one or four goals at one per cycle, then for each dequeued
// cell reads its queue entry and its walls and checks every open neighbor
// direction; every neighbor check is a distance RAM read followed by a
// conditional write.
module maze_flood_fill_distance_unit #(
  parameter int MAZE_SIDE   = mffd_pkg::MFFD_MAZE_SIDE,
  parameter int QUEUE_DEPTH = mffd_pkg::MFFD_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  mffd_pkg::cmd_t  cmd,
  output logic            done,
  output mffd_pkg::result_t result
);

  import mffd_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [4:0] SIDE = 5'(MAZE_SIDE);

  // Sequencer registers.
  state_e               state, state_next;
  logic [8:0]           idx, idx_next;
  cmd_t                 req, req_next;
  logic [1:0]           dir, dir_next;
  logic [7:0]           cur_cell, cur_cell_next;
  logic [LEVEL_W-1:0]   cur_level, cur_level_next;
  logic [3:0]           cur_walls, cur_walls_next;
  logic                 found, found_next;
  logic [QAW-1:0]       q_head, q_head_next;
  logic [QCW-1:0]       q_count, q_count_next;
  logic                 done_next;
  result_t              res, res_next;

  // Memory ports.
  logic                 wall_we;
  logic [7:0]           wall_waddr, wall_raddr, wall_wdata, wall_rdata;
  logic                 dist_we;
  logic [7:0]           dist_waddr, dist_raddr;
  logic [LEVEL_W-1:0]   dist_wdata, dist_rdata;
  logic                 q_we;
  logic [QAW-1:0]       q_waddr, q_raddr;
  logic [QUEUE_W-1:0]   q_wdata, q_rdata;

  // Helper values.
  nb_t                  rec_nb, fl_nb;
  logic [QCW:0]         tail_sum;
  logic [QAW-1:0]       tail;
  logic [7:0]           seed;
  logic [1:0]           opp;

  mffd_ram #(.W(8), .DEPTH(CELLS)) u_wall_ram (
    .clk(clk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
    .raddr(wall_raddr), .rdata(wall_rdata)
  );

  mffd_ram #(.W(LEVEL_W), .DEPTH(CELLS)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  mffd_ram #(.W(QUEUE_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // The tail slot wraps at the queue depth, which need not be a power of two.
  always_comb begin
    tail_sum = {1'b0, (QCW)'(q_head)} + {1'b0, q_count};
    if (tail_sum >= (QCW+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (QCW+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[QAW-1:0];
  end

  assign rec_nb = neighbor(req.cell_req, dir, SIDE);
  assign fl_nb  = neighbor(cur_cell, dir, SIDE);
  assign seed   = seed_cell(req.goal_mode, idx[1:0], req.cell_req);
  assign opp    = dir + 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      idx     <= '0;
      found   <= 1'b0;
      q_head  <= '0;
      q_count <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      found   <= found_next;
      q_head  <= q_head_next;
      q_count <= q_count_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req       <= req_next;
    dir       <= dir_next;
    cur_cell  <= cur_cell_next;
    cur_level <= cur_level_next;
    cur_walls <= cur_walls_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    req_next       = req;
    dir_next       = dir;
    cur_cell_next  = cur_cell;
    cur_level_next = cur_level;
    cur_walls_next = cur_walls;
    found_next     = found;
    q_head_next    = q_head;
    q_count_next   = q_count;
    done_next      = 1'b0;
    res_next       = res;

    wall_we    = 1'b0;
    wall_waddr = idx[7:0];
    wall_wdata = '0;
    wall_raddr = idx[7:0];
    dist_we    = 1'b0;
    dist_waddr = idx[7:0];
    dist_wdata = '0;
    dist_raddr = req.mouse_cell;
    q_we       = 1'b0;
    q_waddr    = tail;
    q_wdata    = '0;
    q_raddr    = q_head;

    case (state)
      // Zero both maps after reset.
      S_CLEAR: begin
        wall_we  = 1'b1;
        dist_we  = 1'b1;
        idx_next = idx + 9'd1;
        if (idx[7:0] == 8'hFF) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_next = cmd;
          idx_next = '0;
          dir_next = '0;
          case (cmd.operation)
            OP_INIT: begin
              wall_raddr = 8'h00;
              state_next = S_INIT_WR;
            end
            OP_RECORD: begin
              wall_raddr = cmd.cell_req;
              state_next = S_REC_CELL;
            end
            OP_FLOOD: begin
              state_next = S_FL_CLR;
            end
            default: begin
              dist_raddr = cmd.cell_req;
              state_next = S_RES_DIST;
            end
          endcase
        end
      end

      // Border setup: write cell idx while reading cell idx+1.
      S_INIT_WR: begin
        wall_we    = 1'b1;
        wall_wdata = wall_rdata | border_mask(idx[7:0], SIDE);
        wall_raddr = idx[7:0] + 8'd1;
        idx_next   = idx + 9'd1;
        if (idx[7:0] == 8'hFF) begin
          done_next  = 1'b1;
          res_next   = '{status: STAT_OK, distance: '0};
          state_next = S_IDLE;
        end
      end

      S_REC_CELL: begin
        if (wall_rdata[7:4] == 4'hF) begin
          done_next  = 1'b1;
          res_next   = '{status: STAT_KNOWN, distance: '0};
          state_next = S_IDLE;
        end else begin
          wall_we    = 1'b1;
          wall_waddr = req.cell_req;
          wall_wdata = wall_rdata | {4'hF, req.walls};
          state_next = S_REC_NB;
        end
      end

      S_REC_NB: begin
        if (rec_nb.valid) begin
          wall_raddr = rec_nb.addr;
          state_next = S_REC_NWR;
        end else if (dir == 2'd3) begin
          done_next  = 1'b1;
          res_next   = '{status: STAT_OK, distance: '0};
          state_next = S_IDLE;
        end else begin
          dir_next = dir + 2'd1;
        end
      end

      // Mirror the known bit, and the wall if there is one, onto the neighbor.
      S_REC_NWR: begin
        wall_we    = 1'b1;
        wall_waddr = rec_nb.addr;
        wall_wdata = wall_rdata | (8'h10 << opp) | ({7'd0, req.walls[dir]} << opp);
        if (dir == 2'd3) begin
          done_next  = 1'b1;
          res_next   = '{status: STAT_OK, distance: '0};
          state_next = S_IDLE;
        end else begin
          dir_next   = dir + 2'd1;
          state_next = S_REC_NB;
        end
      end

      S_FL_CLR: begin
        dist_we  = 1'b1;
        idx_next = idx + 9'd1;
        if (idx[7:0] == 8'hFF) begin
          idx_next     = '0;
          q_head_next  = '0;
          q_count_next = '0;
          found_next   = 1'b0;
          state_next   = S_FL_SEED;
        end
      end

      S_FL_SEED: begin
        dist_we    = 1'b1;
        dist_waddr = seed;
        dist_wdata = LEVEL_W'(1);
        if (q_count < (QCW)'(QUEUE_DEPTH)) begin
          q_we         = 1'b1;
          q_wdata      = {LEVEL_W'(1), seed};
          q_count_next = q_count + (QCW)'(1);
        end
        if (seed == req.mouse_cell) found_next = 1'b1;
        idx_next = idx + 9'd1;
        if (req.goal_mode != GOAL_CENTER || idx[1:0] == 2'd3) begin
          state_next = S_FL_POP;
        end
      end

      S_FL_POP: begin
        if (q_count == '0 || found) begin
          state_next = S_FL_END;
        end else begin
          q_raddr      = q_head;
          q_head_next  = (q_head == (QAW)'(QUEUE_DEPTH - 1)) ? '0 : q_head + (QAW)'(1);
          q_count_next = q_count - (QCW)'(1);
          state_next   = S_FL_CELL;
        end
      end

      S_FL_CELL: begin
        cur_cell_next  = q_rdata[7:0];
        cur_level_next = q_rdata[QUEUE_W-1:8] + LEVEL_W'(1);
        wall_raddr     = q_rdata[7:0];
        dir_next       = '0;
        state_next     = S_FL_WALL;
      end

      S_FL_WALL: begin
        cur_walls_next = wall_rdata[3:0];
        state_next     = S_FL_NRD;
      end

      S_FL_NRD: begin
        if (!cur_walls[dir] && fl_nb.valid) begin
          dist_raddr = fl_nb.addr;
          state_next = S_FL_NCHK;
        end else if (dir == 2'd3) begin
          state_next = S_FL_POP;
        end else begin
          dir_next = dir + 2'd1;
        end
      end

      S_FL_NCHK: begin
        if (dist_rdata == '0) begin
          dist_we    = 1'b1;
          dist_waddr = fl_nb.addr;
          dist_wdata = cur_level;
          if (q_count < (QCW)'(QUEUE_DEPTH)) begin
            q_we         = 1'b1;
            q_wdata      = {cur_level, fl_nb.addr};
            q_count_next = q_count + (QCW)'(1);
          end
          if (fl_nb.addr == req.mouse_cell) found_next = 1'b1;
        end
        if (dir == 2'd3) begin
          state_next = S_FL_POP;
        end else begin
          dir_next   = dir + 2'd1;
          state_next = S_FL_NRD;
        end
      end

      S_FL_END: begin
        if (found) begin
          dist_raddr = req.mouse_cell;
          state_next = S_RES_DIST;
        end else begin
          done_next  = 1'b1;
          res_next   = '{status: STAT_NOT_REACHED, distance: '0};
          state_next = S_IDLE;
        end
      end

      S_RES_DIST: begin
        done_next  = 1'b1;
        res_next   = '{status: STAT_OK, distance: dist_rdata};
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign result = res;

endmodule

// ===== sv/mffd_checker.sv =====
// Port-level checker of the maze flood fill distance unit, bound to the top level.
`include "maze_flood_fill_distance_unit_macros.svh"

module mffd_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input mffd_pkg::cmd_t    cmd,
  input logic              done,
  input mffd_pkg::result_t result
);

  import mffd_pkg::*;

  logic accept;
  logic err_result;
  assign accept     = start && !busy;
  assign err_result = done && (result.status != STAT_OK);

  `MFFD_ASSERT(a_accept_busy, accept |=> busy, "accepted command did not raise busy")
  `MFFD_ASSERT(a_cmd_known, accept |-> !$isunknown(cmd), "accepted command has unknown bits")
  `MFFD_ASSERT(a_done_after_work, done |-> $past(busy), "result without a command at work")
  `MFFD_ASSERT(a_single_strobe, done |=> !done, "result strobe held for two cycles")
  `MFFD_ASSERT_ALWAYS(a_error_no_dist, err_result |-> (result.distance == '0), "error has a distance")

endmodule

bind maze_flood_fill_distance_unit mffd_checker u_mffd_checker (.*);
